FILE: rtl/core/buffer_pool_with_ready_queue_macros.svh
// Assertion macros for the buffer pool.
`ifndef BUFFER_POOL_WITH_READY_QUEUE_MACROS_SVH
`define BUFFER_POOL_WITH_READY_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
`define BPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("bpq assertion failed");
`define BPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("bpq assertion failed");
`else
`define BPQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BPQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/bpq_pkg.sv
`default_nettype none
package bpq_pkg;
	localparam int MaxBuffers = 256;
	localparam int IdxW       = 8;
	localparam int LinkW      = 9;
	localparam int AlignBits  = 3;

	localparam logic [2:0] OP_ALLOC = 3'd0;
	localparam logic [2:0] OP_FREE  = 3'd1;
	localparam logic [2:0] OP_PUSH  = 3'd2;
	localparam logic [2:0] OP_POP   = 3'd3;
	localparam logic [2:0] OP_LAST  = 3'd4;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NONE      = 2'd1;
	localparam logic [1:0] ST_BAD       = 2'd2;
	localparam logic [1:0] ST_NOT_OWNED = 2'd3;

	localparam logic CFG_COUNT = 1'b0;
	localparam logic CFG_SIZE  = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/core/buffer_pool_with_ready_queue.sv
// Channel  Dir  Signals                 Contents
// s_axis   in   tvalid/tready/tdata     opcode[2:0], byte_offset[26:3]
// m_axis   out  tvalid/tready/tdata     status[1:0], buffer_index[9:2], buffer_offset[33:10]
// cfg      in   valid/ready/index/data  register index, write data
// One transaction at a time in the core. Free and push pass through the bit-serial
// divider (24 steps), check, link/flag read, write-back and result load; a push onto
// a non-empty ready queue adds a tail-link step. A bad address stops after the check;
// alloc and pop skip the divider and check; none, set_last and unused go straight to
// the result load. A rebuild after reset or any config write sweeps the link memory,
// during which no stream input is taken. The result register frees the core once
// loaded; a held result stalls the core only when the next result is ready to load.
`default_nettype none
module buffer_pool_with_ready_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // opcode, byte_offset
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // status, buffer_index, buffer_offset
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DIV, S_CHK, S_RD, S_UPD, S_TAIL, S_OUT
	} state_t;

	state_t state_q;
	logic [8:0]  count_q;
	logic [15:0] size_q;
	logic [16:0] asize;
	logic [8:0]  clr_q;
	logic [2:0]  op_q;
	logic [23:0] dvd_q;
	logic [23:0] rem_q;
	logic [23:0] quo_q;
	logic [4:0]  step_q;
	logic [7:0]  idx_q;
	logic [8:0]  free_head_q;
	logic        free_empty_q;
	logic [7:0]  ready_head_q;
	logic [7:0]  ready_tail_q;
	logic        ready_empty_q;
	logic        last_q;
	logic [1:0]  st_q;
	logic        show_q;
	logic        outv_q;
	logic [39:0] outd_q;

	// Link and ownership memories, one read port each, registered read.
	logic [8:0] link_mem [bpq_pkg::MaxBuffers];
	logic       flag_mem [bpq_pkg::MaxBuffers];
	logic [8:0] link_rd_q;
	logic       flag_rd_q;
	logic       lwe, fwe, fwd;
	logic [7:0] la, fa, ra;
	logic [8:0] ld;

	assign asize = (17'(size_q) + 17'd7) & ~17'd7;
	assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE) || (state_q == S_CLEAR);
	assign m_axis_tvalid = outv_q;
	assign m_axis_tdata = outd_q;

	// Divider step: restoring, one quotient bit per cycle.
	logic [24:0] trial;
	logic [24:0] prod;
	assign trial = {rem_q, dvd_q[23]} - {8'd0, asize};
	assign prod = 25'(idx_q) * 25'(asize);

	always_ff @(posedge clk) begin
		if (lwe) link_mem[la] <= ld;
		if (fwe) flag_mem[fa] <= fwd;
		link_rd_q <= link_mem[ra];
		flag_rd_q <= flag_mem[ra];
	end

	// Memory write control; free and push write back only for an owned buffer.
	always_comb begin
		lwe = 1'b0; fwe = 1'b0; fwd = 1'b0;
		la = idx_q; fa = idx_q; ld = 9'd256; ra = idx_q;
		case (state_q)
			S_CLEAR: begin
				lwe = 1'b1; fwe = 1'b1; la = clr_q[7:0]; fa = clr_q[7:0];
				ld = ((clr_q + 9'd1) < count_q) ? clr_q + 9'd1 : 9'd256;
			end
			S_IDLE: ra = (s_axis_tdata[2:0] == bpq_pkg::OP_POP)
				? ready_head_q : free_head_q[7:0];
			S_UPD: begin
				fwe = (op_q == bpq_pkg::OP_ALLOC) || (op_q == bpq_pkg::OP_POP) || flag_rd_q;
				fwd = (op_q == bpq_pkg::OP_ALLOC) || (op_q == bpq_pkg::OP_POP);
				if (op_q == bpq_pkg::OP_FREE) begin
					lwe = flag_rd_q; ld = free_empty_q ? 9'd256 : free_head_q;
				end else if (op_q == bpq_pkg::OP_PUSH) begin
					lwe = flag_rd_q; ld = 9'd256;
				end
			end
			S_TAIL: begin
				lwe = 1'b1; la = ready_tail_q; ld = {1'b0, idx_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR; count_q <= '0; size_q <= '0; clr_q <= '0;
			free_head_q <= '0; free_empty_q <= 1'b1; ready_head_q <= '0;
			ready_tail_q <= '0; ready_empty_q <= 1'b1; last_q <= 1'b0;
			outv_q <= 1'b0; op_q <= '0; step_q <= '0;
			dvd_q <= '0; rem_q <= '0; quo_q <= '0; idx_q <= '0;
			st_q <= '0; show_q <= 1'b0; outd_q <= '0;
		end else begin
			if (outv_q && m_axis_tready) outv_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bpq_pkg::CFG_COUNT) count_q <= cfg_data[8:0];
				else size_q <= cfg_data;
				state_q <= S_CLEAR; clr_q <= '0;
				free_head_q <= '0; ready_head_q <= '0; ready_tail_q <= '0;
				ready_empty_q <= 1'b1; last_q <= 1'b0;
				free_empty_q <= (cfg_index == bpq_pkg::CFG_COUNT)
					? (cfg_data[8:0] == 9'd0) : (count_q == 9'd0);
			end else begin
				case (state_q)
					S_CLEAR: begin
						if (count_q > 9'd256) count_q <= 9'd256;
						clr_q <= clr_q + 9'd1;
						if (clr_q == 9'd255) state_q <= S_IDLE;
					end
					S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
						op_q <= (s_axis_tdata[2:0] == bpq_pkg::OP_PUSH && last_q)
							? bpq_pkg::OP_FREE : s_axis_tdata[2:0];
						dvd_q <= s_axis_tdata[26:3]; rem_q <= '0; step_q <= '0;
						idx_q <= (s_axis_tdata[2:0] == bpq_pkg::OP_POP)
							? ready_head_q : free_head_q[7:0];
						st_q <= bpq_pkg::ST_NONE; show_q <= 1'b0;
						case (s_axis_tdata[2:0])
							bpq_pkg::OP_ALLOC: state_q <= (last_q || free_empty_q)
								? S_OUT : S_RD;
							bpq_pkg::OP_FREE, bpq_pkg::OP_PUSH: state_q <= S_DIV;
							bpq_pkg::OP_POP: state_q <= ready_empty_q ? S_OUT : S_RD;
							bpq_pkg::OP_LAST: begin
								last_q <= 1'b1; st_q <= bpq_pkg::ST_OK; state_q <= S_OUT;
							end
							default: state_q <= S_OUT;
						endcase
					end
					S_DIV: begin
						if (!trial[24]) rem_q <= trial[23:0];
						else rem_q <= {rem_q[22:0], dvd_q[23]};
						quo_q <= {quo_q[22:0], !trial[24]};
						dvd_q <= {dvd_q[22:0], 1'b0};
						step_q <= step_q + 5'd1;
						if (step_q == 5'd23) state_q <= S_CHK;
					end
					S_CHK: begin
						idx_q <= quo_q[7:0];
						if (asize == 17'd0 || rem_q != 24'd0 || quo_q >= 24'(count_q)) begin
							st_q <= bpq_pkg::ST_BAD; state_q <= S_OUT;
						end else state_q <= S_RD;
					end
					S_RD: state_q <= S_UPD;
					S_UPD: begin
						st_q <= bpq_pkg::ST_OK; show_q <= 1'b1; state_q <= S_OUT;
						case (op_q)
							bpq_pkg::OP_ALLOC: begin
								free_head_q <= link_rd_q;
								free_empty_q <= link_rd_q[8];
							end
							bpq_pkg::OP_POP: begin
								if (idx_q == ready_tail_q) ready_empty_q <= 1'b1;
								else ready_head_q <= link_rd_q[7:0];
							end
							default: if (!flag_rd_q) begin
								st_q <= bpq_pkg::ST_NOT_OWNED;
							end else if (op_q == bpq_pkg::OP_FREE) begin
								free_head_q <= {1'b0, idx_q}; free_empty_q <= 1'b0;
							end else begin
								ready_empty_q <= 1'b0;
								if (ready_empty_q) begin
									ready_head_q <= idx_q; ready_tail_q <= idx_q;
								end else state_q <= S_TAIL;
							end
						endcase
					end
					// old tail links to the pushed buffer, then it becomes the tail
					S_TAIL: begin
						ready_tail_q <= idx_q; state_q <= S_OUT;
					end
					S_OUT: if (!outv_q) begin
						outv_q <= 1'b1;
						outd_q <= {6'd0, show_q ? prod[23:0] : 24'd0,
							show_q ? idx_q : 8'd0, st_q};
						state_q <= S_IDLE;
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	// Interface checks.
	logic out_bad;
	assign out_bad = outv_q && (outd_q[1:0] == bpq_pkg::ST_BAD);
	`include "buffer_pool_with_ready_queue_macros.svh"
	`BPQ_ASSERT_IMP(a_no_in_clear, clk, arst_n, state_q == S_CLEAR, !s_axis_tready)
	`BPQ_ASSERT_NXT(a_out_hold, clk, arst_n, outv_q && !m_axis_tready, outv_q)
	`BPQ_ASSERT_IMP(a_bad_zero, clk, arst_n, out_bad, outd_q[33:2] == 32'd0)
endmodule
`default_nettype wire
